@@ sv/tkls_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-K logit selection package
// Shared sizes, payload structs and control bundles for the selection chain.
// ----------------------------------------------------------------------------
package tkls_pkg;

    localparam int TOP_K     = 8;
    localparam int MAX_ITEMS = 2048;

    localparam int VAL_W = 16;
    localparam int POS_W = 11;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic signed [VAL_W-1:0] logit;
        logic                    final_item;
    } item_t;

    typedef struct packed {
        logic        [POS_W-1:0] move_index;
        logic signed [VAL_W-1:0] score;
        logic                    end_of_list;
    } result_t;

    // One kept logit with its arrival position.
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic        [POS_W-1:0] pos;
    } entry_t;

    // Broadcast from the top level to every insertion cell.
    typedef struct packed {
        logic                    enable;
        logic                    clear;
        logic signed [VAL_W-1:0] value;
        logic        [POS_W-1:0] pos;
    } ins_ctrl_t;

    // Broadcast from the top level to every output cell.
    typedef struct packed {
        logic load;
        logic shift;
    } drn_ctrl_t;

endpackage

@@ sv/tkls_cell.sv @@
// ----------------------------------------------------------------------------
// Top-K insertion cell
// Holds one ranked entry; takes the new logit or its left neighbour's entry.
// ----------------------------------------------------------------------------
module tkls_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tkls_pkg::ins_ctrl_t ctrl,
    input  tkls_pkg::entry_t   left,
    input  logic               left_take,
    output tkls_pkg::entry_t   held,
    output logic               take,
    output tkls_pkg::entry_t   held_next
);
    import tkls_pkg::*;

    logic                    valid_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic        [POS_W-1:0] pos_reg;
    entry_t                  fresh;

    assign held.valid = valid_reg;
    assign held.value = value_reg;
    assign held.pos   = pos_reg;

    // Strictly greater, so an equal later logit stays behind this one.
    assign take = ctrl.enable && (!valid_reg || (ctrl.value > value_reg));

    always_comb
    begin
        fresh.valid = 1'b1;
        fresh.value = ctrl.value;
        fresh.pos   = ctrl.pos;
        if (!take)
        begin
            held_next = held;
        end
        else if (left_take)
        begin
            held_next = left;
        end
        else
        begin
            held_next = fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= held_next.valid && !ctrl.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= held_next.value;
        pos_reg   <= held_next.pos;
    end

endmodule

@@ sv/tkls_drain_cell.sv @@
// ----------------------------------------------------------------------------
// Top-K output cell
// Holds one ranked result; loaded in parallel, then shifted toward the port.
// ----------------------------------------------------------------------------
module tkls_drain_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tkls_pkg::drn_ctrl_t ctrl,
    input  tkls_pkg::entry_t   load_data,
    input  tkls_pkg::entry_t   right,
    output tkls_pkg::entry_t   held
);
    import tkls_pkg::*;

    logic                    valid_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic        [POS_W-1:0] pos_reg;
    entry_t                  held_next;

    assign held.valid = valid_reg;
    assign held.value = value_reg;
    assign held.pos   = pos_reg;

    always_comb
    begin
        if (ctrl.load)
        begin
            held_next = load_data;
        end
        else if (ctrl.shift)
        begin
            held_next = right;
        end
        else
        begin
            held_next = held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= held_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= held_next.value;
        pos_reg   <= held_next.pos;
    end

endmodule

@@ sv/top_k_logit_selection_top.sv @@
// ----------------------------------------------------------------------------
// Top-K logit selection, top level
// Accepts one logit per cycle; the K-cell chain is ranked by value on the fly.
// Throughput: one logit per cycle; a final logit waits while a list drains.
// First result in the cycle after a final logit, then one per unstalled cycle.
// A list of n results holds the output cells until all n have shifted out.
// Reset: asynchronous, clears all valid bits and the position count at once.
// ----------------------------------------------------------------------------
module top_k_logit_selection_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tkls_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tkls_pkg::result_t result
);
    import tkls_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             vector_end;

    ins_ctrl_t ins_ctrl;
    drn_ctrl_t drn_ctrl;

    entry_t chain_held [TOP_K];
    entry_t chain_next [TOP_K];
    logic   chain_take [TOP_K];
    entry_t drain_held [TOP_K];
    entry_t drain_right [TOP_K];

    // The output cells form a valid prefix, so the head tells if any is busy.
    assign item_stall = item_valid && item.final_item && drain_held[0].valid;
    assign accept     = item_valid && !item_stall;
    assign vector_end = accept && item.final_item;

    assign ins_ctrl.enable = accept && (cnt_reg < CNT_W'(MAX_ITEMS));
    assign ins_ctrl.clear  = vector_end;
    assign ins_ctrl.value  = item.logit;
    assign ins_ctrl.pos    = POS_W'(cnt_reg);

    assign drn_ctrl.load  = vector_end;
    assign drn_ctrl.shift = result_valid && !result_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (vector_end)
        begin
            cnt_next = '0;
        end
        else if (ins_ctrl.enable)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < TOP_K; gi++)
        begin : g_cell
            entry_t left;
            logic   left_take;

            if (gi == 0)
            begin : g_head
                assign left      = '0;
                assign left_take = 1'b0;
            end
            else
            begin : g_body
                assign left      = chain_held[gi-1];
                assign left_take = chain_take[gi-1];
            end

            if (gi == TOP_K - 1)
            begin : g_tail
                assign drain_right[gi] = '0;
            end
            else
            begin : g_mid
                assign drain_right[gi] = drain_held[gi+1];
            end

            tkls_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ins_ctrl),
                .left      (left),
                .left_take (left_take),
                .held      (chain_held[gi]),
                .take      (chain_take[gi]),
                .held_next (chain_next[gi])
            );

            // The final logit is ranked first, so the list is copied after it.
            tkls_drain_cell u_drain (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (drn_ctrl),
                .load_data (chain_next[gi]),
                .right     (drain_right[gi]),
                .held      (drain_held[gi])
            );
        end
    endgenerate

    assign result_valid       = drain_held[0].valid;
    assign result.move_index  = drain_held[0].pos;
    assign result.score       = drain_held[0].value;
    assign result.end_of_list = !drain_right[0].valid;

endmodule

@@ sv/tkls_checker.sv @@
// ----------------------------------------------------------------------------
// Top-K logit selection checker
// Port-level properties of the selection block, bound to the top level.
// ----------------------------------------------------------------------------
module tkls_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input tkls_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input tkls_pkg::result_t result
);
    import tkls_pkg::*;

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Input is held back only for a final logit while a list still drains.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_valid && item.final_item && result_valid)
        else $error("input stalled without a pending list");

    // Every accepted final logit yields at least one result.
    a_list_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.final_item |=> result_valid)
        else $error("no result after final logit");

    // A list runs without gaps up to its end marker.
    a_list_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.end_of_list |=> result_valid)
        else $error("gap inside a result list");

    // The next list cannot follow in the cycle straight after an end marker.
    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result.end_of_list |=> !result_valid)
        else $error("result valid straight after end of list");

endmodule

bind top_k_logit_selection_top tkls_checker u_tkls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
